// ===== rtl/rxa_pkg.sv =====
package rxa_pkg;

	// width of the converted value and of one stored digit (radix up to 36)
	localparam int VALUE_W = 64;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 8;

	localparam logic [7:0] RADIX_MIN      = 8'd2;
	localparam logic [7:0] RADIX_MAX      = 8'd36;
	localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = DIGIT_W'(10);

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	// per-cycle commands shared by every cell of the row
	typedef struct packed {
		logic clear;
		logic shift;
	} cell_ctrl_t;

	// doubling carry handed from one cell to the next
	typedef struct packed {
		logic valid;
		logic carry;
	} cell_link_t;

	// digit value to upper-case ascii
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DECIMAL_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d - DECIMAL_DIGITS);
		end
		return c;
	endfunction

endpackage

// ===== rtl/rxa_cell.sv =====
module rxa_cell
	import rxa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic [DIGIT_W-1:0] radix,
	input  cell_link_t         link_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output cell_link_t         link_out,
	output logic [DIGIT_W-1:0] digit
);

	logic [DIGIT_W-1:0] digit_q;
	cell_link_t         link_q;
	logic [DIGIT_W:0]   sum;
	logic [DIGIT_W:0]   diff;
	logic               wrap;

	// double the digit, add the incoming carry, reduce once by the radix
	always_comb begin
		sum  = {digit_q, link_in.carry};
		diff = sum - {1'b0, radix};
		wrap = (sum >= {1'b0, radix});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			link_q  <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
			link_q  <= '0;
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
			link_q  <= '0;
		end else if (link_in.valid) begin
			digit_q      <= wrap ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
			link_q.valid <= 1'b1;
			link_q.carry <= wrap;
		end else begin
			link_q <= '0;
		end
	end

	assign digit    = digit_q;
	assign link_out = link_q;

endmodule

// ===== rtl/radix_integer_to_ascii.sv =====
// Converts a 64-bit unsigned value to right-aligned, left-padded ASCII text in
// any radix from 2 to 36 (digits 0-9 then A-Z), one character per valid strobe,
// most significant first, with last on the final character. A request is taken
// when start is high and busy is low. The value is shifted in one bit per cycle
// into a row of MAX_CHARS digit cells; each cell passes its carry to the next
// cell through a register. The row is then shifted out through the top cell,
// with padding positions above the requested width skipped. A request holds
// busy through conversion and shift-out, and the next request is taken only
// after it. A radix outside 2..36 is taken without raising busy and gives no
// characters. The receiver cannot stall: each character is on the outputs for
// exactly one cycle. Only the least significant MAX_CHARS digits are kept when
// the number is longer.
module radix_integer_to_ascii
	import rxa_pkg::*;
#(
	parameter int MAX_CHARS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value,
	input  logic [7:0]         radix,
	input  logic [7:0]         min_width,
	input  logic [7:0]         pad_char,
	output logic               valid,
	output logic [CHAR_W-1:0]  ascii_char,
	output logic               last
);

	localparam int CNT_W   = $clog2(VALUE_W + MAX_CHARS + 1);
	localparam int POS_W   = $clog2(MAX_CHARS);
	localparam int WIDTH_W = $clog2(MAX_CHARS + 1);
	localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_W + MAX_CHARS - 1);
	localparam logic [CNT_W-1:0] FEED_LEN  = CNT_W'(VALUE_W);

	state_t state_q, state_d;

	logic [VALUE_W-1:0] value_q;
	logic [DIGIT_W-1:0] radix_q;
	logic [WIDTH_W-1:0] width_q;
	logic [7:0]         pad_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic               overflow_q;
	logic               started_q;
	logic               valid_q;
	logic               last_q;
	logic [CHAR_W-1:0]  char_q;

	logic       radix_ok;
	logic       accept;
	logic       conv_done;
	logic       in_digits;
	logic       emit;
	cell_ctrl_t ctrl;

	logic [DIGIT_W-1:0] digit_w [MAX_CHARS];
	cell_link_t         link_w  [MAX_CHARS+1];

	assign radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
	assign accept    = start && (state_q == ST_IDLE);
	assign conv_done = (state_q == ST_CONV) && (cnt_q == CONV_LAST);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and row commands
	always_comb begin
		state_d    = state_q;
		ctrl.clear = 1'b0;
		ctrl.shift = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start && radix_ok) begin
					state_d    = ST_CONV;
					ctrl.clear = 1'b1;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				ctrl.shift = 1'b1;
				if (pos_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture and bit feed
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			radix_q <= radix[DIGIT_W-1:0];
			pad_q   <= pad_char;
			if (min_width == 8'd0) begin
				width_q <= WIDTH_W'(1);
			end else if (min_width > 8'(MAX_CHARS)) begin
				width_q <= WIDTH_W'(MAX_CHARS);
			end else begin
				width_q <= min_width[WIDTH_W-1:0];
			end
		end else if (state_q == ST_CONV) begin
			value_q <= value_q << 1;
		end
	end

	// conversion counter, emit position and leading-digit tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pos_q      <= '0;
			overflow_q <= 1'b0;
			started_q  <= 1'b0;
		end else if (accept) begin
			cnt_q      <= '0;
			overflow_q <= 1'b0;
			started_q  <= 1'b0;
		end else if (state_q == ST_CONV) begin
			cnt_q <= cnt_q + 1'b1;
			pos_q <= POS_W'(MAX_CHARS - 1);
			if (link_w[MAX_CHARS].valid && link_w[MAX_CHARS].carry) begin
				overflow_q <= 1'b1;
			end
		end else if (state_q == ST_EMIT) begin
			pos_q <= pos_q - 1'b1;
			if (in_digits) begin
				started_q <= 1'b1;
			end
		end
	end

	// feed of the value bits into the low cell, most significant first
	assign link_w[0].valid = (state_q == ST_CONV) && (cnt_q < FEED_LEN);
	assign link_w[0].carry = value_q[VALUE_W-1];

	// digit cell row
	for (genvar i = 0; i < MAX_CHARS; i++) begin : g_cell
		logic [DIGIT_W-1:0] below;
		if (i == 0) begin : g_low
			assign below = '0;
		end else begin : g_up
			assign below = digit_w[i-1];
		end
		rxa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.radix    (radix_q),
			.link_in  (link_w[i]),
			.digit_in (below),
			.link_out (link_w[i+1]),
			.digit    (digit_w[i])
		);
	end

	// character select at the top of the row
	assign in_digits = overflow_q || started_q || (digit_w[MAX_CHARS-1] != '0) ||
		(pos_q == '0);
	assign emit = (state_q == ST_EMIT) &&
		(in_digits || (WIDTH_W'(pos_q) < width_q));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= emit;
			last_q  <= emit && (pos_q == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= in_digits ? digit_to_ascii(digit_w[MAX_CHARS-1]) : pad_q;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign valid      = valid_q;
	assign last       = last_q;
	assign ascii_char = char_q;

	// characters only come out of the shift-out phase
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(state_q == ST_EMIT))
		else $error("character strobe outside shift-out");

	a_last_marks_char: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> valid)
		else $error("last without a character");

	a_good_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && radix_ok) |=> (busy && state_q == ST_CONV))
		else $error("valid request did not start conversion");

	a_quiet_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> !valid)
		else $error("character strobe during conversion");

endmodule

// ===== dv/radix_integer_to_ascii_tb.sv =====
`timescale 1ns / 100ps

module radix_integer_to_ascii_tb;
	import rxa_pkg::*;

	localparam int MAX_TEXT    = 64;
	localparam int CLK_HALF    = 5;
	localparam int RESET_CYCLES = 10;
	localparam int RANDOM_TEXTS = 480;
	localparam int MAX_GAP     = 6;
	// how long one request holds busy
	localparam int REQ_CYCLES  = 64 + 2 * MAX_TEXT;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} text_char_t;

	// expected text of accepted requests, one entry per character
	class text_scoreboard;
		text_char_t  pending_text[$];
		int unsigned mismatches;
		int unsigned chars_checked;
		int unsigned requests;
		int unsigned silent_requests;

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// render the padded text of one request and queue its characters
		function void note_request(logic [VALUE_W-1:0] v, logic [7:0] r, logic [7:0] w,
				logic [7:0] pad);
			logic [CHAR_W-1:0]  cells [MAX_TEXT];
			logic [VALUE_W-1:0] rest;
			logic [VALUE_W-1:0] d;
			int                 pos;
			int                 eff_w;
			int                 count;
			requests++;
			if (r < RADIX_MIN || r > RADIX_MAX) begin
				silent_requests++;
				return;
			end
			if (w == 8'd0)
				eff_w = 1;
			else if (int'(w) > MAX_TEXT)
				eff_w = MAX_TEXT;
			else
				eff_w = int'(w);
			foreach (cells[i])
				cells[i] = pad;
			// digits from the least significant end
			rest = v;
			pos  = MAX_TEXT;
			do begin
				d = rest % VALUE_W'(r);
				pos--;
				if (d < 10)
					cells[pos] = "0" + CHAR_W'(d);
				else
					cells[pos] = "A" + CHAR_W'(d - 10);
				rest = rest / VALUE_W'(r);
			end while (rest != 0 && pos > 0);
			count = MAX_TEXT - pos;
			if (count < eff_w)
				count = eff_w;
			for (int k = MAX_TEXT - count; k < MAX_TEXT; k++)
				pending_text.push_back('{ch: cells[k], fin: (k == MAX_TEXT - 1)});
		endfunction

		task check_char(logic [CHAR_W-1:0] ch, logic fin);
			text_char_t want;
			if (pending_text.size() == 0) begin
				report_mismatch($sformatf("unexpected char %02h last %b", ch, fin));
				return;
			end
			want = pending_text.pop_front();
			chars_checked++;
			if (ch !== want.ch)
				report_mismatch($sformatf("char %02h, expected %02h", ch, want.ch));
			if (fin !== want.fin)
				report_mismatch($sformatf("last %b, expected %b (char %02h)", fin, want.fin,
					want.ch));
		endtask
	endclass

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic [VALUE_W-1:0] value      = '0;
	logic [7:0]         radix      = 8'd0;
	logic [7:0]         min_width  = 8'd0;
	logic [7:0]         pad_char   = 8'd0;
	logic               busy;
	logic               valid;
	logic [CHAR_W-1:0]  ascii_char;
	logic               last;

	text_scoreboard sb = new();
	int unsigned    cycle_count = 0;
	int             burst_left  = 0;

	radix_integer_to_ascii u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.radix      (radix),
		.min_width  (min_width),
		.pad_char   (pad_char),
		.valid      (valid),
		.ascii_char (ascii_char),
		.last       (last)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// every strobed character is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && valid === 1'b1)
			sb.check_char(ascii_char, last);
	end

	// present one request and hold it until taken, with a random lead-in gap outside bursts
	task send_request(logic [VALUE_W-1:0] v, logic [7:0] r, logic [7:0] w, logic [7:0] pad);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, MAX_GAP);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		value     <= v;
		radix     <= r;
		min_width <= w;
		pad_char  <= pad;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_request(v, r, w, pad);
	endtask

	// a power of the radix, up to the largest that fits, or one below it
	function automatic logic [VALUE_W-1:0] radix_boundary(logic [7:0] r);
		logic [VALUE_W-1:0] p;
		int                 steps;
		p     = 1;
		steps = $urandom_range(1, VALUE_W);
		repeat (steps) begin
			if (p <= {VALUE_W{1'b1}} / VALUE_W'(r))
				p = p * VALUE_W'(r);
		end
		return p - VALUE_W'($urandom_range(0, 1));
	endfunction

	task send_random_request();
		logic [VALUE_W-1:0] v;
		logic [7:0]         r;
		logic [7:0]         w;
		int                 pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			r = 8'($urandom_range(0, 255));
		else if (pick < 25)
			case ($urandom_range(0, 3))
				0: r = 8'd2;
				1: r = 8'd10;
				2: r = 8'd16;
				default: r = 8'd36;
			endcase
		else
			r = 8'($urandom_range(RADIX_MIN, RADIX_MAX));
		case ($urandom_range(0, 3))
			0: v = {$urandom, $urandom};
			1: v = {$urandom, $urandom} >> $urandom_range(0, VALUE_W - 1);
			2: v = VALUE_W'($urandom_range(0, 100));
			default: v = radix_boundary((r < RADIX_MIN || r > RADIX_MAX) ? 8'd10 : r);
		endcase
		if ($urandom_range(0, 4) != 0)
			w = 8'($urandom_range(0, MAX_TEXT + 6));
		else
			w = 8'($urandom_range(0, 255));
		send_request(v, r, w, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int random_texts;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every radix class, padding corner cases
		send_request('0, 8'd10, 8'd0, " ");
		send_request('0, 8'd2, 8'd64, "*");
		send_request('1, 8'd2, 8'd0, " ");
		send_request('1, 8'd36, 8'd0, " ");
		send_request('1, 8'd16, 8'd255, 8'h00);
		send_request('1, 8'd10, 8'd65, 8'hFF);
		send_request(64'd35, 8'd36, 8'd1, "0");
		send_request(64'd255, 8'd16, 8'd8, "0");
		send_request(64'h8000_0000_0000_0000, 8'd2, 8'd1, "-");
		send_request(64'd12345, 8'd10, 8'd64, 8'hAA);
		send_request(64'd12345, 8'd10, 8'd3, 8'h55);
		send_request(64'd1, 8'd3, 8'd0, " ");
		send_request(64'd99, 8'd0, 8'd4, " ");
		send_request(64'd99, 8'd1, 8'd4, " ");
		send_request(64'd99, 8'd37, 8'd4, " ");
		send_request(64'd99, 8'd255, 8'd255, 8'hFF);
		send_request(64'd99, 8'd128, 8'd4, " ");
		send_request(64'h0123_4567_89AB_CDEF, 8'd16, 8'd20, "0");
		send_request(64'hFEDC_BA98_7654_3210, 8'd8, 8'd63, "#");
		send_request(64'd1295, 8'd36, 8'd2, " ");
		send_request(64'd1296, 8'd36, 8'd2, " ");
		send_request(64'hAAAA_AAAA_AAAA_AAAA, 8'd2, 8'd0, 8'h80);
		send_request(64'h5555_5555_5555_5555, 8'd4, 8'd33, 8'h7F);

		// random: mostly valid radices, some stretches without gaps
		random_texts = 0;
		while (random_texts < RANDOM_TEXTS) begin
			if (burst_left == 0 && $urandom_range(0, 39) == 0)
				burst_left = $urandom_range(5, 15);
			send_random_request();
			random_texts++;
		end
		start <= 1'b0;

		// drain, then watch for stray characters
		while (sb.pending_text.size() != 0)
			@(posedge clk);
		repeat (REQ_CYCLES + 8) @(posedge clk);

		$display("covered %0d requests, %0d with an out-of-range radix",
			sb.requests, sb.silent_requests);
		$display("checked %0d characters, %0d mismatches", sb.chars_checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_text.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
